// ===== design/aab_pkg.sv =====
// ============================================================================
// aab_pkg: shared types and constants for the analog axis button block
// Widths, register indexes, reset values and the divide-by-five constant.
// ============================================================================
package aab_pkg;

    localparam int SAMPLE_BITS    = 12;
    localparam int AXIS_BITS      = 12;
    localparam int TIME_BITS      = 48;
    localparam int DUR_BITS       = 32;
    localparam int CFG_DATA_BITS  = 32;
    localparam int CFG_INDEX_BITS = 3;

    // compare width covering both the filter value and the press thresholds
    localparam int CMP_BITS = (SAMPLE_BITS > AXIS_BITS ? SAMPLE_BITS : AXIS_BITS) + 1;

    localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = '1;

    // floor(x/5) == (x * 52429) >> 18 for every x below 2^18
    localparam logic [15:0] DIV5_RECIP = 16'd52429;
    localparam int          DIV5_SHIFT = 18;

    localparam logic [AXIS_BITS-1:0] AXIS_LOW_RST       = '0;
    localparam logic [AXIS_BITS-1:0] AXIS_HIGH_RST      = AXIS_BITS'(4095);
    localparam logic [DUR_BITS-1:0]  REPEAT_DELAY_RST   = DUR_BITS'(500000);
    localparam logic [DUR_BITS-1:0]  REPEAT_INTERVAL_RST = DUR_BITS'(100000);
    localparam logic [DUR_BITS-1:0]  ACCEL_DELAY_RST    = DUR_BITS'(3000000);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_INVERT_INPUT    = 3'd0,
        CFG_AXIS_LOW        = 3'd1,
        CFG_AXIS_HIGH       = 3'd2,
        CFG_REPEAT_DELAY    = 3'd3,
        CFG_REPEAT_INTERVAL = 3'd4,
        CFG_ACCEL_DELAY     = 3'd5
    } t_cfg_index;

endpackage

// ===== design/aab_in_if.sv =====
// ============================================================================
// aab_in_if: sample request channel
// One converter sample with its failure flag and timestamp.
// ============================================================================
interface aab_in_if;
    logic                             valid;
    logic                             ready;
    logic [aab_pkg::SAMPLE_BITS-1:0]  raw_sample;
    logic                             read_failed;
    logic [aab_pkg::TIME_BITS-1:0]    now_us;

    modport source (output valid, output raw_sample, output read_failed, output now_us,
                    input ready);
    modport sink   (input valid, input raw_sample, input read_failed, input now_us,
                    output ready);
endinterface

// ===== design/aab_out_if.sv =====
// ============================================================================
// aab_out_if: key event channel
// Filtered axis value plus press and accelerate flags.
// ============================================================================
interface aab_out_if;
    logic                             valid;
    logic                             ready;
    logic [aab_pkg::SAMPLE_BITS-1:0]  filtered_value;
    logic                             positive_press;
    logic                             negative_press;
    logic                             accelerated;

    modport source (output valid, output filtered_value, output positive_press,
                    output negative_press, output accelerated, input ready);
    modport sink   (input valid, input filtered_value, input positive_press,
                    input negative_press, input accelerated, output ready);
endinterface

// ===== design/analog_axis_button_autorepeat.sv =====
// ============================================================================
// analog_axis_button_autorepeat: analog axis to key press converter
// Low-pass filters converter samples, thresholds them into two keys and
// generates auto-repeat presses from a shared repeat timer.
// ============================================================================
//
//  channel   | dir | handshake           | payload
//  ----------+-----+---------------------+------------------------------------
//  i_axis    | in  | valid / ready       | raw_sample, read_failed, now_us
//  o_key     | out | valid / ready       | filtered_value, positive_press,
//            |     |                     | negative_press, accelerated
//  i_cfg_*   | in  | i_cfg_we (no wait)  | i_cfg_index, i_cfg_data
//
//  One request per cycle sustained while o_key is ready; a request taken passes
//  through the input register, then the result register, on its way to o_key.
//  The filter and key state registers close a loop around the compute stage.
//  Reset is synchronous; config returns to its defaults.
//  When o_key stalls, the result register holds and one more request parks
//  in the input register; only then does i_axis.ready drop.
//
module analog_axis_button_autorepeat (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    aab_in_if.sink                               i_axis,
    aab_out_if.source                            o_key,
    input  logic                                 i_cfg_we,
    input  logic [aab_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  logic [aab_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);

    localparam int SB = aab_pkg::SAMPLE_BITS;
    localparam int AB = aab_pkg::AXIS_BITS;
    localparam int TB = aab_pkg::TIME_BITS;
    localparam int DB = aab_pkg::DUR_BITS;
    localparam int CB = aab_pkg::CMP_BITS;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic          r_invert;
    logic [AB-1:0] r_axis_low;
    logic [AB-1:0] r_axis_high;
    logic [DB-1:0] r_rep_delay;
    logic [DB-1:0] r_rep_interval;
    logic [DB-1:0] r_accel_delay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_invert       <= 1'b0;
            r_axis_low     <= aab_pkg::AXIS_LOW_RST;
            r_axis_high    <= aab_pkg::AXIS_HIGH_RST;
            r_rep_delay    <= aab_pkg::REPEAT_DELAY_RST;
            r_rep_interval <= aab_pkg::REPEAT_INTERVAL_RST;
            r_accel_delay  <= aab_pkg::ACCEL_DELAY_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                aab_pkg::CFG_INVERT_INPUT:    r_invert       <= i_cfg_data[0];
                aab_pkg::CFG_AXIS_LOW:        r_axis_low     <= i_cfg_data[AB-1:0];
                aab_pkg::CFG_AXIS_HIGH:       r_axis_high    <= i_cfg_data[AB-1:0];
                aab_pkg::CFG_REPEAT_DELAY:    r_rep_delay    <= i_cfg_data[DB-1:0];
                aab_pkg::CFG_REPEAT_INTERVAL: r_rep_interval <= i_cfg_data[DB-1:0];
                aab_pkg::CFG_ACCEL_DELAY:     r_accel_delay  <= i_cfg_data[DB-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Axis geometry, recomputed every cycle from the config registers.
    // The user must change config only while idle (the block does not enforce
    // this), so these are settled before the next request reaches the compute stage.
    // ------------------------------------------------------------------
    logic [AB-1:0]    hi_eff;
    logic [AB-1:0]    span;
    logic [AB+15:0]   thr_prod;
    logic [AB-1:0]    thr;
    logic [AB-1:0]    mid;
    logic [AB-1:0]    r_clamp_hi;
    logic [AB:0]      r_press_hi;   // mid + 20% of span
    logic [AB-1:0]    r_press_lo;   // mid - 20% of span, never negative

    always_comb begin
        // inverted range collapses to the low bound
        hi_eff   = (r_axis_high < r_axis_low) ? r_axis_low : r_axis_high;
        span     = hi_eff - r_axis_low;
        thr_prod = span * aab_pkg::DIV5_RECIP;
        thr      = AB'(thr_prod >> aab_pkg::DIV5_SHIFT);
        mid      = r_axis_low + (span >> 1);
    end

    always_ff @(posedge i_clk) begin
        r_clamp_hi <= hi_eff;
        r_press_hi <= {1'b0, mid} + {1'b0, thr};
        r_press_lo <= mid - thr;
    end

    // ------------------------------------------------------------------
    // Handshake: input register, then result register
    // ------------------------------------------------------------------
    logic r_s1_valid;
    logic r_out_valid;
    logic s2_free;
    logic s1_adv;
    logic in_accept;

    assign s2_free      = !r_out_valid || o_key.ready;
    assign s1_adv       = r_s1_valid && s2_free;
    assign i_axis.ready = !r_s1_valid || s2_free;
    assign in_accept    = i_axis.valid && i_axis.ready;

    // ------------------------------------------------------------------
    // Input register: sample conditioning and deadline sums
    // ------------------------------------------------------------------
    logic [SB-1:0] r_sample;
    logic [TB-1:0] r_now;
    logic [TB-1:0] r_t_delay;   // now + repeat delay
    logic [TB-1:0] r_t_int;     // now + repeat interval
    logic [TB-1:0] r_t_accel;   // now + accelerate delay

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            if (i_axis.read_failed) begin
                r_sample <= '0;
            end else if (r_invert) begin
                r_sample <= aab_pkg::FULL_SCALE - i_axis.raw_sample;
            end else begin
                r_sample <= i_axis.raw_sample;
            end
            r_now     <= i_axis.now_us;
            r_t_delay <= i_axis.now_us + TB'(r_rep_delay);
            r_t_int   <= i_axis.now_us + TB'(r_rep_interval);
            r_t_accel <= i_axis.now_us + TB'(r_accel_delay);
        end
    end

    // ------------------------------------------------------------------
    // Persistent filter and key state
    // ------------------------------------------------------------------
    logic [SB-1:0] r_filt_val;
    logic          r_primed;
    logic          r_pos_held;
    logic          r_neg_held;
    logic [TB-1:0] r_next_rep;   // zero means disarmed
    logic [TB-1:0] r_accel_t;

    // ------------------------------------------------------------------
    // Compute stage
    // ------------------------------------------------------------------
    logic signed [SB:0] diff;
    logic [SB-1:0]      mag;
    logic [SB+15:0]     step_prod;
    logic [SB-1:0]      step;
    logic [SB-1:0]      n_filt_val;
    logic [CB-1:0]      fext;
    logic [CB-1:0]      v;
    logic               trig_pos;
    logic               trig_neg;
    logic               n_pos_held;
    logic               n_neg_held;
    logic [TB-1:0]      nrt_mid;
    logic [TB-1:0]      at_mid;
    logic [TB-1:0]      n_next_rep;
    logic [TB-1:0]      n_accel_t;
    logic               pos_press;
    logic               neg_press;
    logic               accel;

    always_comb begin
        // f += trunc((s - f) / 5), magnitude divided then sign restored
        diff      = $signed({1'b0, r_sample}) - $signed({1'b0, r_filt_val});
        mag       = diff[SB] ? SB'(-diff) : SB'(diff);
        step_prod = mag * aab_pkg::DIV5_RECIP;
        step      = SB'(step_prod >> aab_pkg::DIV5_SHIFT);
        if (!r_primed) begin
            n_filt_val = r_sample;
        end else if (diff[SB]) begin
            n_filt_val = r_filt_val - step;
        end else begin
            n_filt_val = r_filt_val + step;
        end

        // clamp into [low, effective high]
        fext = CB'(n_filt_val);
        if (fext < CB'(r_axis_low)) begin
            v = CB'(r_axis_low);
        end else if (fext > CB'(r_clamp_hi)) begin
            v = CB'(r_clamp_hi);
        end else begin
            v = fext;
        end
        trig_pos = v >= CB'(r_press_hi);
        trig_neg = v <= CB'(r_press_lo);

        accel = 1'b0;

        // positive key first; it may rearm the shared timer
        pos_press  = 1'b0;
        n_pos_held = trig_pos;
        nrt_mid    = r_next_rep;
        at_mid     = r_accel_t;
        if (trig_pos) begin
            if (r_pos_held) begin
                if (r_next_rep != '0 && r_now >= r_next_rep) begin
                    pos_press = 1'b1;
                    nrt_mid   = r_t_int;
                    accel     = r_now >= r_accel_t;
                end
            end else begin
                pos_press = 1'b1;
                nrt_mid   = r_t_delay;
                at_mid    = r_t_accel;
            end
        end

        // negative key sees the timer as the positive key left it
        neg_press  = 1'b0;
        n_neg_held = trig_neg;
        n_next_rep = nrt_mid;
        n_accel_t  = at_mid;
        if (trig_neg) begin
            if (r_neg_held) begin
                if (nrt_mid != '0 && r_now >= nrt_mid) begin
                    neg_press  = 1'b1;
                    n_next_rep = r_t_int;
                    accel      = r_now >= at_mid;
                end
            end else begin
                neg_press  = 1'b1;
                n_next_rep = r_t_delay;
                n_accel_t  = r_t_accel;
            end
        end
    end

    // ------------------------------------------------------------------
    // Control and state registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_primed    <= 1'b0;
            r_filt_val  <= '0;
            r_pos_held  <= 1'b0;
            r_neg_held  <= 1'b0;
            r_next_rep  <= '0;
            r_accel_t   <= '0;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_key.ready) begin
                r_out_valid <= 1'b0;
            end

            if (s1_adv) begin
                r_primed   <= 1'b1;
                r_filt_val <= n_filt_val;
                r_pos_held <= n_pos_held;
                r_neg_held <= n_neg_held;
                r_next_rep <= n_next_rep;
                r_accel_t  <= n_accel_t;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic [SB-1:0] r_out_filt;
    logic          r_out_pos;
    logic          r_out_neg;
    logic          r_out_accel;

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_filt  <= n_filt_val;
            r_out_pos   <= pos_press;
            r_out_neg   <= neg_press;
            r_out_accel <= accel;
        end
    end

    assign o_key.valid          = r_out_valid;
    assign o_key.filtered_value = r_out_filt;
    assign o_key.positive_press = r_out_pos;
    assign o_key.negative_press = r_out_neg;
    assign o_key.accelerated    = r_out_accel;

endmodule

// ===== design/aab_checker.sv =====
// ============================================================================
// aab_checker: port-level checks for the analog axis button block
// Watches the request and key channels; attached to the top level by bind.
// ============================================================================
module aab_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_ready,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic [aab_pkg::SAMPLE_BITS-1:0]   i_out_filt,
    input  logic                              i_out_pos,
    input  logic                              i_out_neg,
    input  logic                              i_out_accel
);

    // reset empties the result register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // with the result register empty the block must take a request
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("request refused with empty result register");

    // accelerate flag only comes with a repeat press
    a_accel_has_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_accel |-> (i_out_pos || i_out_neg))
        else $error("accelerated without a press");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_out_filt) && $stable(i_out_pos) && $stable(i_out_neg)
            && $stable(i_out_accel))
        else $error("result changed while stalled");

endmodule

bind analog_axis_button_autorepeat aab_checker u_aab_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_axis.ready),
    .i_out_valid (o_key.valid),
    .i_out_ready (o_key.ready),
    .i_out_filt  (o_key.filtered_value),
    .i_out_pos   (o_key.positive_press),
    .i_out_neg   (o_key.negative_press),
    .i_out_accel (o_key.accelerated)
);
